>>> hw/rtl/samx_pkg.sv
// Shared types and constants of the stereo mixer with level meter.
`default_nettype none

package samx_pkg;

    localparam int NUM_CH      = 3;
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 10;
    localparam int TICK_W      = 8;
    localparam int LEVEL_W     = 7;
    localparam int SUM_W       = 26;
    localparam int FRAMES_W    = 9;
    localparam int TERM_W      = 28;
    localparam int MIX_W       = 29;
    localparam int DIV_SHIFT   = 12;
    localparam int QUO_W       = MIX_W - DIV_SHIFT;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = GAIN_W;
    localparam int TICK_LSB    = 2 * NUM_CH * SAMPLE_W;
    localparam int IN_DATA_W   = TICK_LSB + TICK_W;
    localparam int OUT_DATA_W  = 48;
    localparam int LEVEL_SCALE = 164;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STEREO_OUTPUT  = 3'd0,
        REG_STEREO_MASK    = 3'd1,
        REG_GAIN_LEFT_CH0  = 3'd2,
        REG_GAIN_RIGHT_CH0 = 3'd3,
        REG_GAIN_LEFT_CH1  = 3'd4,
        REG_GAIN_RIGHT_CH1 = 3'd5,
        REG_GAIN_LEFT_CH2  = 3'd6,
        REG_GAIN_RIGHT_CH2 = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef struct packed {
        logic                           stereo_output;
        logic [NUM_CH-1:0]              stereo_mask;
        logic [NUM_CH-1:0][GAIN_W-1:0]  gain_left;
        logic [NUM_CH-1:0][GAIN_W-1:0]  gain_right;
    } cfg_t;

    typedef struct packed {
        logic                       is_tick;
        logic [TICK_W-1:0]          tick_count;
        logic signed [MIX_W-1:0]    left;
        logic signed [MIX_W-1:0]    right;
    } mix_t;

endpackage

`default_nettype wire

>>> hw/rtl/stereo_audio_mixer_with_meter.sv
// Top level of the three-channel stereo mixer with peak level meter.
// Throughput: one item per cycle while m_tready does not stall the output; each
// item passes in order through all five registers of the pipeline
// (input, multiply-add, scale/accumulate, meter reciprocal multiply, result).
// Reset: rst_n clears config, pipeline valids, meter sums, frame count and held
// levels at once; no clearing pass, the block is ready right after reset.
`default_nettype none

module stereo_audio_mixer_with_meter #(
    parameter int METER_WINDOW = 441
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // ch0_left, ch0_right, ch1_left, ch1_right, ch2_left, ch2_right, tick_count
    input  wire logic [samx_pkg::IN_DATA_W-1:0]         s_tdata,
    // operation
    input  wire logic [0:0]                             s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // out_left, out_right, level_left, level_right, zero fill
    output logic [samx_pkg::OUT_DATA_W-1:0]             m_tdata,
    // is_sample
    output logic [0:0]                                  m_tuser,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [samx_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [samx_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int PAD_W = samx_pkg::OUT_DATA_W - 2 * samx_pkg::SAMPLE_W
                           - 2 * samx_pkg::LEVEL_W;

    samx_pkg::cfg_t                         cfg;
    samx_pkg::mix_t                         mix;
    logic                                   mix_valid;
    logic                                   mix_ready;
    logic signed [samx_pkg::SAMPLE_W-1:0]   out_left;
    logic signed [samx_pkg::SAMPLE_W-1:0]   out_right;
    logic                                   out_is_sample;
    logic [samx_pkg::LEVEL_W-1:0]           level_left;
    logic [samx_pkg::LEVEL_W-1:0]           level_right;

    samx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    samx_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_data   (s_tdata),
        .mix_valid (mix_valid),
        .mix_ready (mix_ready),
        .mix       (mix)
    );

    samx_meter #(
        .METER_WINDOW (METER_WINDOW)
    ) u_meter (
        .clk           (clk),
        .rst_n         (rst_n),
        .mix_valid     (mix_valid),
        .mix_ready     (mix_ready),
        .mix           (mix),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_left      (out_left),
        .out_right     (out_right),
        .out_is_sample (out_is_sample),
        .level_left    (level_left),
        .level_right   (level_right)
    );

    assign m_tdata = {{PAD_W{1'b0}}, level_right, level_left, out_right, out_left};
    assign m_tuser = out_is_sample;

endmodule

`default_nettype wire

>>> hw/rtl/samx_cfg.sv
// Configuration register file: mode, stereo mask and per-channel gains.
`default_nettype none

module samx_cfg (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [samx_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [samx_pkg::CFG_DATA_W-1:0]        cfg_data,
    output samx_pkg::cfg_t                              cfg
);

    samx_pkg::cfg_t cfg_reg;
    samx_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (samx_pkg::cfg_reg_t'(cfg_index))
                samx_pkg::REG_STEREO_OUTPUT:
                    cfg_next.stereo_output = cfg_data[0];
                samx_pkg::REG_STEREO_MASK:
                    cfg_next.stereo_mask = cfg_data[samx_pkg::NUM_CH-1:0];
                samx_pkg::REG_GAIN_LEFT_CH0:  cfg_next.gain_left[0]  = cfg_data;
                samx_pkg::REG_GAIN_RIGHT_CH0: cfg_next.gain_right[0] = cfg_data;
                samx_pkg::REG_GAIN_LEFT_CH1:  cfg_next.gain_left[1]  = cfg_data;
                samx_pkg::REG_GAIN_RIGHT_CH1: cfg_next.gain_right[1] = cfg_data;
                samx_pkg::REG_GAIN_LEFT_CH2:  cfg_next.gain_left[2]  = cfg_data;
                samx_pkg::REG_GAIN_RIGHT_CH2: cfg_next.gain_right[2] = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/samx_mix.sv
// Input register and gain multiply-add stage of the mixer.
`default_nettype none

module samx_mix (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire samx_pkg::cfg_t                     cfg,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               in_op,
    input  wire logic [samx_pkg::IN_DATA_W-1:0]     in_data,
    output logic                                    mix_valid,
    input  wire logic                               mix_ready,
    output samx_pkg::mix_t                          mix
);

    localparam int SAMPLE_W = samx_pkg::SAMPLE_W;
    localparam int TERM_W   = samx_pkg::TERM_W;
    localparam int MIX_W    = samx_pkg::MIX_W;
    localparam int NUM_CH   = samx_pkg::NUM_CH;

    logic                               a_valid_reg;
    logic                               a_op_reg;
    logic [samx_pkg::IN_DATA_W-1:0]     a_data_reg;
    logic                               b_valid_reg;
    samx_pkg::mix_t                     b_mix_reg;
    samx_pkg::mix_t                     b_mix_next;

    logic                               a_load;
    logic                               b_load;

    logic signed [TERM_W-1:0]           term_l [NUM_CH];
    logic signed [TERM_W-1:0]           term_r [NUM_CH];
    logic signed [MIX_W-1:0]            sum_l;
    logic signed [MIX_W-1:0]            sum_r;

    assign b_load    = !b_valid_reg || mix_ready;
    assign a_load    = !a_valid_reg || b_load;
    assign in_ready  = a_load;
    assign mix_valid = b_valid_reg;
    assign mix       = b_mix_reg;

    for (genvar i = 0; i < NUM_CH; i++)
    begin : g_ch
        logic signed [SAMPLE_W-1:0]         sl;
        logic signed [SAMPLE_W-1:0]         sr;
        logic signed [SAMPLE_W:0]           op_l;
        logic signed [SAMPLE_W:0]           op_r;
        logic signed [samx_pkg::GAIN_W:0]   gl;
        logic signed [samx_pkg::GAIN_W:0]   gr;
        logic signed [TERM_W-1:0]           prod_l;
        logic signed [TERM_W-1:0]           prod_r;
        logic signed [TERM_W-1:0]           round_l;
        logic                               fold;

        assign sl   = $signed(a_data_reg[2*i*SAMPLE_W +: SAMPLE_W]);
        assign sr   = $signed(a_data_reg[(2*i+1)*SAMPLE_W +: SAMPLE_W]);
        // mono output folds a stereo channel into (l + r) / 2
        assign fold = !cfg.stereo_output && cfg.stereo_mask[i];
        assign op_l = fold ? ((SAMPLE_W+1)'(sl) + (SAMPLE_W+1)'(sr)) : (SAMPLE_W+1)'(sl);
        assign op_r = cfg.stereo_mask[i] ? (SAMPLE_W+1)'(sr) : (SAMPLE_W+1)'(sl);
        assign gl   = $signed({1'b0, cfg.gain_left[i]});
        assign gr   = $signed({1'b0, cfg.gain_right[i]});

        assign prod_l  = TERM_W'(gl) * TERM_W'(op_l);
        assign prod_r  = TERM_W'(gr) * TERM_W'(op_r);
        // halve toward zero
        assign round_l = prod_l + $signed({{(TERM_W-1){1'b0}}, prod_l[TERM_W-1]});

        assign term_l[i] = fold ? (round_l >>> 1) : prod_l;
        assign term_r[i] = prod_r;
    end

    always_comb
    begin
        sum_l = '0;
        sum_r = '0;
        for (int i = 0; i < NUM_CH; i++)
        begin
            sum_l = sum_l + MIX_W'(term_l[i]);
            sum_r = sum_r + MIX_W'(term_r[i]);
        end
    end

    always_comb
    begin
        b_mix_next.is_tick    = (samx_pkg::op_t'(a_op_reg) == samx_pkg::OP_TICK);
        b_mix_next.tick_count = a_data_reg[samx_pkg::TICK_LSB +: samx_pkg::TICK_W];
        b_mix_next.left       = sum_l;
        b_mix_next.right      = cfg.stereo_output ? sum_r : sum_l;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_load)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && in_valid)
        begin
            a_op_reg   <= in_op;
            a_data_reg <= in_data;
        end
        if (b_load && a_valid_reg)
        begin
            b_mix_reg <= b_mix_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/samx_meter.sv
// Scaling, clamp, level meter accumulation and peak hold with decay.
`default_nettype none

module samx_meter #(
    parameter int METER_WINDOW = 441
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   mix_valid,
    output logic                                        mix_ready,
    input  wire samx_pkg::mix_t                         mix,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [samx_pkg::SAMPLE_W-1:0]        out_left,
    output logic signed [samx_pkg::SAMPLE_W-1:0]        out_right,
    output logic                                        out_is_sample,
    output logic [samx_pkg::LEVEL_W-1:0]                level_left,
    output logic [samx_pkg::LEVEL_W-1:0]                level_right
);

    localparam int SAMPLE_W  = samx_pkg::SAMPLE_W;
    localparam int MIX_W     = samx_pkg::MIX_W;
    localparam int QUO_W     = samx_pkg::QUO_W;
    localparam int SUM_W     = samx_pkg::SUM_W;
    localparam int FRAMES_W  = samx_pkg::FRAMES_W;
    localparam int LEVEL_W   = samx_pkg::LEVEL_W;
    localparam int TICK_W    = samx_pkg::TICK_W;
    localparam int DIV_SHIFT = samx_pkg::DIV_SHIFT;

    // level = sum / (window * 164), exact via reciprocal multiply
    localparam int DIV_K    = METER_WINDOW * samx_pkg::LEVEL_SCALE;
    localparam int DIV_BITS = $clog2(DIV_K);
    localparam int SHIFT    = SUM_W + DIV_BITS;
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIV_K) - 64'd1) / 64'(DIV_K);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [FRAMES_W-1:0] WIN = FRAMES_W'(METER_WINDOW);
    localparam logic signed [QUO_W-1:0] CLAMP_HI = QUO_W'(samx_pkg::OUT_MAX);
    localparam logic signed [QUO_W-1:0] CLAMP_LO = -CLAMP_HI;

    // meter state
    logic [SUM_W-1:0]               meter_sum_left_reg;
    logic [SUM_W-1:0]               meter_sum_right_reg;
    logic [FRAMES_W-1:0]            meter_frames_reg;
    logic [SUM_W-1:0]               meter_sum_left_next;
    logic [SUM_W-1:0]               meter_sum_right_next;
    logic [FRAMES_W-1:0]            meter_frames_next;

    // stage C
    logic                           c_valid_reg;
    logic                           c_is_tick_reg;
    logic [TICK_W-1:0]              c_tick_reg;
    logic                           c_window_reg;
    logic signed [SAMPLE_W-1:0]     c_out_left_reg;
    logic signed [SAMPLE_W-1:0]     c_out_right_reg;
    logic [SUM_W-1:0]               c_sum_left_reg;
    logic [SUM_W-1:0]               c_sum_right_reg;

    // stage D
    logic                           d_valid_reg;
    logic                           d_is_tick_reg;
    logic [TICK_W-1:0]              d_tick_reg;
    logic                           d_window_reg;
    logic signed [SAMPLE_W-1:0]     d_out_left_reg;
    logic signed [SAMPLE_W-1:0]     d_out_right_reg;
    logic [PROD_W-1:0]              d_prod_left_reg;
    logic [PROD_W-1:0]              d_prod_right_reg;

    // result stage
    logic                           out_valid_reg;
    logic                           out_is_sample_reg;
    logic signed [SAMPLE_W-1:0]     out_left_reg;
    logic signed [SAMPLE_W-1:0]     out_right_reg;
    logic [LEVEL_W-1:0]             held_level_left_reg;
    logic [LEVEL_W-1:0]             held_level_right_reg;
    logic [LEVEL_W-1:0]             held_level_left_next;
    logic [LEVEL_W-1:0]             held_level_right_next;

    logic                           c_load;
    logic                           d_load;
    logic                           out_load;
    logic                           c_take;

    logic signed [MIX_W-1:0]        biased_l;
    logic signed [MIX_W-1:0]        biased_r;
    logic signed [QUO_W-1:0]        quo_l;
    logic signed [QUO_W-1:0]        quo_r;
    logic [QUO_W-1:0]               mag_l;
    logic [QUO_W-1:0]               mag_r;
    logic signed [SAMPLE_W-1:0]     clamp_l;
    logic signed [SAMPLE_W-1:0]     clamp_r;
    logic [SUM_W-1:0]               acc_l;
    logic [SUM_W-1:0]               acc_r;
    logic [FRAMES_W-1:0]            frames_inc;
    logic                           window;

    logic [PROD_W-1:0]              lvl_quo_l;
    logic [PROD_W-1:0]              lvl_quo_r;
    logic [LEVEL_W-1:0]             lvl_l;
    logic [LEVEL_W-1:0]             lvl_r;

    assign out_load  = !out_valid_reg || out_ready;
    assign d_load    = !d_valid_reg || out_load;
    assign c_load    = !c_valid_reg || d_load;
    assign mix_ready = c_load;
    assign c_take    = c_load && mix_valid;

    assign out_valid     = out_valid_reg;
    assign out_left      = out_left_reg;
    assign out_right     = out_right_reg;
    assign out_is_sample = out_is_sample_reg;
    assign level_left    = held_level_left_reg;
    assign level_right   = held_level_right_reg;

    // divide by 4096 toward zero
    assign biased_l = mix.left  + $signed({{(QUO_W){1'b0}}, {DIV_SHIFT{mix.left[MIX_W-1]}}});
    assign biased_r = mix.right + $signed({{(QUO_W){1'b0}}, {DIV_SHIFT{mix.right[MIX_W-1]}}});
    assign quo_l    = $signed(biased_l[MIX_W-1:DIV_SHIFT]);
    assign quo_r    = $signed(biased_r[MIX_W-1:DIV_SHIFT]);
    assign mag_l    = quo_l[QUO_W-1] ? QUO_W'(-quo_l) : QUO_W'(quo_l);
    assign mag_r    = quo_r[QUO_W-1] ? QUO_W'(-quo_r) : QUO_W'(quo_r);

    assign clamp_l = (quo_l > CLAMP_HI) ? samx_pkg::OUT_MAX :
                     (quo_l < CLAMP_LO) ? -samx_pkg::OUT_MAX : quo_l[SAMPLE_W-1:0];
    assign clamp_r = (quo_r > CLAMP_HI) ? samx_pkg::OUT_MAX :
                     (quo_r < CLAMP_LO) ? -samx_pkg::OUT_MAX : quo_r[SAMPLE_W-1:0];

    assign acc_l      = meter_sum_left_reg  + SUM_W'(mag_l);
    assign acc_r      = meter_sum_right_reg + SUM_W'(mag_r);
    assign frames_inc = meter_frames_reg + FRAMES_W'(1);
    assign window     = (frames_inc == WIN);

    always_comb
    begin
        meter_sum_left_next  = meter_sum_left_reg;
        meter_sum_right_next = meter_sum_right_reg;
        meter_frames_next    = meter_frames_reg;
        if (c_take && !mix.is_tick)
        begin
            if (window)
            begin
                meter_sum_left_next  = '0;
                meter_sum_right_next = '0;
                meter_frames_next    = '0;
            end
            else
            begin
                meter_sum_left_next  = acc_l;
                meter_sum_right_next = acc_r;
                meter_frames_next    = frames_inc;
            end
        end
    end

    assign lvl_quo_l = d_prod_left_reg  >> SHIFT;
    assign lvl_quo_r = d_prod_right_reg >> SHIFT;
    assign lvl_l = (lvl_quo_l > PROD_W'(samx_pkg::LEVEL_MAX)) ? samx_pkg::LEVEL_MAX
                                                               : lvl_quo_l[LEVEL_W-1:0];
    assign lvl_r = (lvl_quo_r > PROD_W'(samx_pkg::LEVEL_MAX)) ? samx_pkg::LEVEL_MAX
                                                               : lvl_quo_r[LEVEL_W-1:0];

    always_comb
    begin
        held_level_left_next  = held_level_left_reg;
        held_level_right_next = held_level_right_reg;
        if (out_load && d_valid_reg)
        begin
            if (d_is_tick_reg)
            begin
                held_level_left_next  = ({1'b0, held_level_left_reg} > d_tick_reg) ?
                    LEVEL_W'({1'b0, held_level_left_reg} - d_tick_reg) : '0;
                held_level_right_next = ({1'b0, held_level_right_reg} > d_tick_reg) ?
                    LEVEL_W'({1'b0, held_level_right_reg} - d_tick_reg) : '0;
            end
            else if (d_window_reg)
            begin
                if (lvl_l > held_level_left_reg)
                begin
                    held_level_left_next = lvl_l;
                end
                if (lvl_r > held_level_right_reg)
                begin
                    held_level_right_next = lvl_r;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_sum_left_reg   <= '0;
            meter_sum_right_reg  <= '0;
            meter_frames_reg     <= '0;
            held_level_left_reg  <= '0;
            held_level_right_reg <= '0;
            c_valid_reg          <= 1'b0;
            d_valid_reg          <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            meter_sum_left_reg   <= meter_sum_left_next;
            meter_sum_right_reg  <= meter_sum_right_next;
            meter_frames_reg     <= meter_frames_next;
            held_level_left_reg  <= held_level_left_next;
            held_level_right_reg <= held_level_right_next;
            if (c_load)
            begin
                c_valid_reg <= mix_valid;
            end
            if (d_load)
            begin
                d_valid_reg <= c_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_take)
        begin
            c_is_tick_reg   <= mix.is_tick;
            c_tick_reg      <= mix.tick_count;
            c_window_reg    <= window;
            c_out_left_reg  <= mix.is_tick ? '0 : clamp_l;
            c_out_right_reg <= mix.is_tick ? '0 : clamp_r;
            c_sum_left_reg  <= acc_l;
            c_sum_right_reg <= acc_r;
        end
        if (d_load && c_valid_reg)
        begin
            d_is_tick_reg    <= c_is_tick_reg;
            d_tick_reg       <= c_tick_reg;
            d_window_reg     <= c_window_reg;
            d_out_left_reg   <= c_out_left_reg;
            d_out_right_reg  <= c_out_right_reg;
            d_prod_left_reg  <= PROD_W'(c_sum_left_reg)  * PROD_W'(RECIP);
            d_prod_right_reg <= PROD_W'(c_sum_right_reg) * PROD_W'(RECIP);
        end
        if (out_load && d_valid_reg)
        begin
            out_is_sample_reg <= !d_is_tick_reg;
            out_left_reg      <= d_out_left_reg;
            out_right_reg     <= d_out_right_reg;
        end
    end

    a_frames_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        meter_frames_reg < WIN)
        else $error("frame count left the meter window");

    a_level_capped: assert property (@(posedge clk) disable iff (!rst_n)
        held_level_left_reg <= samx_pkg::LEVEL_MAX && held_level_right_reg <= samx_pkg::LEVEL_MAX)
        else $error("held level above full scale");

    a_tick_zero_mix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_is_sample_reg |-> out_left_reg == '0 && out_right_reg == '0)
        else $error("tick result carries nonzero mix");

    a_tick_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && d_valid_reg && d_is_tick_reg |=>
            held_level_left_reg <= $past(held_level_left_reg) &&
            held_level_right_reg <= $past(held_level_right_reg))
        else $error("decay tick raised a held level");

endmodule

`default_nettype wire
